FILE: hdl/knn_pkg.sv
package knn_pkg;

  localparam int DEF_MAX_NEIGHBOURS = 16;
  localparam int DEF_MAX_LENGTH     = 1024;
  localparam int DEF_SAMPLE_BITS    = 16;

  localparam int PORT_SAMPLE_W = 16;
  localparam int LABEL_W       = 32;
  localparam int DIST_W        = 48;
  localparam int RANK_W        = 4;
  localparam int TOP_COUNT_W   = 5;
  localparam int SERIES_LEN_W  = 11;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 11;
  localparam int READ_LIMIT    = 16;
  localparam int READ_N_W      = 5;

  localparam logic [DIST_W-1:0] DIST_ONES = {DIST_W{1'b1}};

  localparam logic [CFG_INDEX_W-1:0] CFG_TOP_COUNT     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SERIES_LENGTH = 2'd1;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_CAND  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef struct packed {
    logic                valid;
    op_t                 op;
    logic [DIST_W-1:0]   dist_val;
    logic [LABEL_W-1:0]  label;
  } list_cmd_t;

endpackage

FILE: hdl/knn_query_mem.sv
module knn_query_mem #(
  parameter int MAX_LENGTH  = knn_pkg::DEF_MAX_LENGTH,
  parameter int SAMPLE_BITS = knn_pkg::DEF_SAMPLE_BITS,
  parameter int LEN_W       = $clog2(MAX_LENGTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  knn_pkg::op_t           op,
  input  logic [SAMPLE_BITS-1:0] sample_ext,
  input  logic [LEN_W-1:0]       eff_len,
  output logic                   cand_last,
  output logic [SAMPLE_BITS-1:0] q
);
  import knn_pkg::*;

  localparam int PW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;

  logic [SAMPLE_BITS-1:0] mem [MAX_LENGTH];
  logic [PW-1:0]          qpos;
  logic [PW-1:0]          cpos;
  logic [PW-1:0]          qp;
  logic [PW-1:0]          cp;
  logic [LEN_W-1:0]       qnxt;
  logic [LEN_W-1:0]       cnxt;
  logic                   q_wrap;

  always_comb begin
    qp        = (LEN_W'(qpos) >= eff_len) ? '0 : qpos;
    cp        = (LEN_W'(cpos) >= eff_len) ? '0 : cpos;
    qnxt      = LEN_W'(qp) + LEN_W'(1);
    cnxt      = LEN_W'(cp) + LEN_W'(1);
    q_wrap    = qnxt >= eff_len;
    cand_last = cnxt >= eff_len;
  end

  always_ff @(posedge clk) begin
    if (accept && op == OP_LOAD) begin
      mem[qp] <= sample_ext;
    end
    if (accept && op == OP_CAND) begin
      q <= mem[cp];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qpos <= '0;
      cpos <= '0;
    end else if (accept) begin
      if (op == OP_LOAD) begin
        qpos <= q_wrap ? '0 : PW'(qnxt);
      end
      if (op == OP_CAND) begin
        cpos <= cand_last ? '0 : PW'(cnxt);
      end
    end
  end

endmodule

FILE: hdl/knn_dist_acc.sv
module knn_dist_acc #(
  parameter int SAMPLE_BITS = knn_pkg::DEF_SAMPLE_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            adv,
  input  logic                            accept,
  input  knn_pkg::op_t                    op,
  input  logic [SAMPLE_BITS-1:0]          sample_ext,
  input  logic [knn_pkg::LABEL_W-1:0]     label,
  input  logic                            cand_last,
  input  logic [SAMPLE_BITS-1:0]          q,
  output knn_pkg::list_cmd_t              cmd
);
  import knn_pkg::*;

  logic                   s1_valid;
  op_t                    s1_op;
  logic [SAMPLE_BITS-1:0] s1_sample;
  logic [LABEL_W-1:0]     s1_label;
  logic                   s1_last;

  logic                   s2_valid;
  op_t                    s2_op;
  logic [DIST_W-1:0]      s2_sq;
  logic [LABEL_W-1:0]     s2_label;
  logic                   s2_last;

  logic [DIST_W-1:0]      running_sum;

  logic signed [SAMPLE_BITS:0] diff;
  logic [SAMPLE_BITS-1:0]      absd;
  logic [2*SAMPLE_BITS-1:0]    sq;
  logic [DIST_W:0]             sum_wide;
  logic [DIST_W-1:0]           sum_sat;

  always_comb begin
    diff     = $signed({s1_sample[SAMPLE_BITS-1], s1_sample}) - $signed({q[SAMPLE_BITS-1], q});
    absd     = diff[SAMPLE_BITS] ? SAMPLE_BITS'(-diff) : SAMPLE_BITS'(diff);
    sq       = absd * absd;
    sum_wide = {1'b0, running_sum} + {1'b0, s2_sq};
    sum_sat  = (sum_wide >= {1'b0, DIST_ONES}) ? DIST_ONES : sum_wide[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      cmd.valid   <= 1'b0;
      running_sum <= '0;
    end else if (adv) begin
      s1_valid  <= accept && op != OP_LOAD;
      s2_valid  <= s1_valid;
      cmd.valid <= s2_valid && (s2_op != OP_CAND || s2_last);
      if (s2_valid && s2_op == OP_CAND) begin
        running_sum <= s2_last ? '0 : sum_sat;
      end
      cmd.op       <= s2_op;
      cmd.dist_val <= sum_sat;
      cmd.label    <= s2_label;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op     <= op;
      s1_sample <= sample_ext;
      s1_label  <= label;
      s1_last   <= cand_last;
      s2_op     <= s1_op;
      s2_sq     <= DIST_W'(sq);
      s2_label  <= s1_label;
      s2_last   <= s1_last;
    end
  end

endmodule

FILE: hdl/knn_topk_list.sv
module knn_topk_list #(
  parameter int MAX_NEIGHBOURS = knn_pkg::DEF_MAX_NEIGHBOURS,
  parameter int K_W            = $clog2(MAX_NEIGHBOURS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  knn_pkg::list_cmd_t            cmd,
  input  logic [K_W-1:0]                eff_k,
  output logic                          done,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          kind,
  output logic [knn_pkg::RANK_W-1:0]    rank,
  output logic [knn_pkg::LABEL_W-1:0]   series_label,
  output logic [knn_pkg::DIST_W-1:0]    distance,
  output logic                          inserted,
  output logic                          last
);
  import knn_pkg::*;

  localparam int IDX_W = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;

  logic [DIST_W-1:0]  best_d [MAX_NEIGHBOURS];
  logic [LABEL_W-1:0] best_l [MAX_NEIGHBOURS];
  logic [DIST_W-1:0]  src_d  [MAX_NEIGHBOURS];
  logic [LABEL_W-1:0] src_l  [MAX_NEIGHBOURS];

  logic [MAX_NEIGHBOURS-1:0] gt;
  logic [MAX_NEIGHBOURS-1:0] first;
  logic                      prev;
  logic                      ins;
  logic [IDX_W-1:0]          pos;

  logic [RANK_W-1:0]   rd_idx;
  logic [IDX_W-1:0]    rd_sel;
  logic [READ_N_W-1:0] rd_n;
  logic                rd_last;
  logic                out_free;
  logic                do_insert;
  logic                do_clear;
  logic                do_read;

  always_comb begin
    prev = 1'b0;
    pos  = '0;
    for (int j = 0; j < MAX_NEIGHBOURS; j++) begin
      gt[j]    = (best_d[j] > cmd.dist_val) && (j < int'(eff_k));
      first[j] = gt[j] && !prev;
      prev     = gt[j];
      if (first[j]) begin
        pos = IDX_W'(j);
      end
    end
    ins = |gt;
    src_d[0] = cmd.dist_val;
    src_l[0] = cmd.label;
    for (int j = 1; j < MAX_NEIGHBOURS; j++) begin
      src_d[j] = best_d[j-1];
      src_l[j] = best_l[j-1];
    end
  end

  always_comb begin
    out_free  = !out_valid || out_ready;
    rd_sel    = IDX_W'(rd_idx);
    rd_n      = (int'(eff_k) > READ_LIMIT) ? READ_N_W'(READ_LIMIT) : READ_N_W'(eff_k);
    rd_last   = (READ_N_W'(rd_idx) + READ_N_W'(1)) == rd_n;
    do_insert = 1'b0;
    do_clear  = 1'b0;
    do_read   = 1'b0;
    done      = 1'b0;
    case (cmd.op)
      OP_CAND: begin
        do_insert = cmd.valid && out_free;
        done      = out_free;
      end
      OP_CLEAR: begin
        do_clear = cmd.valid;
        done     = 1'b1;
      end
      OP_READ: begin
        do_read = cmd.valid && out_free;
        done    = out_free && rd_last;
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < MAX_NEIGHBOURS; j++) begin
        best_d[j] <= DIST_ONES;
        best_l[j] <= '0;
      end
    end else if (do_clear) begin
      for (int j = 0; j < MAX_NEIGHBOURS; j++) begin
        best_d[j] <= DIST_ONES;
        best_l[j] <= '0;
      end
    end else if (do_insert) begin
      for (int j = 0; j < MAX_NEIGHBOURS; j++) begin
        if (gt[j]) begin
          best_d[j] <= first[j] ? cmd.dist_val : src_d[j];
          best_l[j] <= first[j] ? cmd.label : src_l[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rd_idx    <= '0;
    end else begin
      if (do_insert || do_read) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (do_read) begin
        rd_idx <= rd_last ? '0 : rd_idx + RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_insert) begin
      kind         <= 1'b0;
      rank         <= ins ? RANK_W'(pos) : '0;
      series_label <= cmd.label;
      distance     <= cmd.dist_val;
      inserted     <= ins;
      last         <= 1'b1;
    end else if (do_read) begin
      kind         <= 1'b1;
      rank         <= rd_idx;
      series_label <= best_l[rd_sel];
      distance     <= best_d[rd_sel];
      inserted     <= 1'b0;
      last         <= rd_last;
    end
  end

endmodule

FILE: hdl/knn_l2_topk_scanner_unit.sv
// Brute-force k-nearest-neighbour scanner on squared Euclidean distance. Load the query
// with operation 0 transactions, then stream candidate elements with operation 1; both
// take one transaction per cycle while the list stage does not stall the input, with the
// query samples held in a single-port RAM read once per candidate element. A candidate's
// last element produces one report once the distance has passed the subtract/square
// stage, the saturating accumulator and the parallel compare-and-shift insert into the
// sorted list. Clear empties the list at the list stage and gives no result. Read-out
// emits min(k,16) list entries, one per cycle while the result side accepts them, and
// stalls the input until its last entry is issued once it reaches the list stage.
// Configure top_count and series_length only while the block is idle.
module knn_l2_topk_scanner_unit #(
  parameter int MAX_NEIGHBOURS = knn_pkg::DEF_MAX_NEIGHBOURS,
  parameter int MAX_LENGTH     = knn_pkg::DEF_MAX_LENGTH,
  parameter int SAMPLE_BITS    = knn_pkg::DEF_SAMPLE_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        operation,
  input  logic signed [knn_pkg::PORT_SAMPLE_W-1:0] sample,
  input  logic [knn_pkg::LABEL_W-1:0]       series_id,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              kind,
  output logic [knn_pkg::RANK_W-1:0]        rank,
  output logic [knn_pkg::LABEL_W-1:0]       series_label,
  output logic [knn_pkg::DIST_W-1:0]        distance,
  output logic                              inserted,
  output logic                              last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [knn_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [knn_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import knn_pkg::*;

  localparam int K_W   = $clog2(MAX_NEIGHBOURS + 1);
  localparam int LEN_W = $clog2(MAX_LENGTH + 1);

  logic [TOP_COUNT_W-1:0]  top_count;
  logic [SERIES_LEN_W-1:0] series_length;
  logic [K_W-1:0]          eff_k;
  logic [LEN_W-1:0]        eff_len;

  logic                   accept;
  logic                   adv;
  logic                   list_done;
  logic                   cand_last;
  op_t                    op;
  logic [SAMPLE_BITS-1:0] sample_ext;
  logic [SAMPLE_BITS-1:0] q;
  list_cmd_t              cmd;

  always_comb begin
    op         = op_t'(operation);
    sample_ext = SAMPLE_BITS'({8'd0, sample});
    eff_k      = (top_count == '0) ? K_W'(1) :
                 (int'(top_count) > MAX_NEIGHBOURS) ? K_W'(MAX_NEIGHBOURS) : K_W'(top_count);
    eff_len    = (series_length == '0) ? LEN_W'(1) :
                 (int'(series_length) > MAX_LENGTH) ? LEN_W'(MAX_LENGTH) : LEN_W'(series_length);
    adv        = !cmd.valid || list_done;
    in_ready   = adv;
    accept     = in_valid && adv;
    cfg_ready  = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_count     <= TOP_COUNT_W'(16);
      series_length <= SERIES_LEN_W'(1024);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TOP_COUNT:     top_count     <= cfg_data[TOP_COUNT_W-1:0];
        CFG_SERIES_LENGTH: series_length <= cfg_data[SERIES_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  knn_query_mem #(
    .MAX_LENGTH  (MAX_LENGTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .LEN_W       (LEN_W)
  ) u_qmem (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .op         (op),
    .sample_ext (sample_ext),
    .eff_len    (eff_len),
    .cand_last  (cand_last),
    .q          (q)
  );

  knn_dist_acc #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_acc (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .accept     (accept),
    .op         (op),
    .sample_ext (sample_ext),
    .label      (series_id),
    .cand_last  (cand_last),
    .q          (q),
    .cmd        (cmd)
  );

  knn_topk_list #(
    .MAX_NEIGHBOURS (MAX_NEIGHBOURS),
    .K_W            (K_W)
  ) u_list (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .eff_k        (eff_k),
    .done         (list_done),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .rank         (rank),
    .series_label (series_label),
    .distance     (distance),
    .inserted     (inserted),
    .last         (last)
  );

endmodule

FILE: hdl/knn_checker.sv
module knn_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            kind,
  input logic [knn_pkg::RANK_W-1:0]      rank,
  input logic [knn_pkg::DIST_W-1:0]      distance,
  input logic                            inserted,
  input logic                            last
);
  import knn_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(distance) && $stable(rank))
    else $error("result changed while stalled");

  // a candidate report is always a single transaction
  a_report_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == 1'b0 |-> last)
    else $error("candidate report without last");

  a_read_not_inserted: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == 1'b1 |-> !inserted)
    else $error("read-out entry flagged inserted");

  a_reject_rank: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == 1'b0 && !inserted |-> rank == '0)
    else $error("rejected candidate with nonzero rank");

  // saturated distance never beats an empty slot
  a_insert_not_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == 1'b0 && inserted |-> distance != DIST_ONES)
    else $error("saturated distance inserted");

endmodule

bind knn_l2_topk_scanner_unit knn_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .kind      (kind),
  .rank      (rank),
  .distance  (distance),
  .inserted  (inserted),
  .last      (last)
);
